FILE: design/scda_pkg.sv
// shared constants, types and codes of the seven-channel decimating accumulator
`timescale 1ns / 1ps

package scda_pkg;

  // channel count and widths
  localparam int NUM_CH      = 7;
  localparam int SAMPLE_W    = 24;
  localparam int SAMPLE_BITS = 24;
  localparam int SUM_W       = 31;
  localparam int CNT_W       = 7;
  localparam int SCALE_W     = 32;
  localparam int FRAC_BITS   = 24;
  localparam int RES_W       = 32;
  localparam int PROD_W      = (SUM_W - 1) + SCALE_W + 1;
  localparam int SHIFTED_W   = PROD_W - FRAC_BITS;

  // ring buffer slot
  localparam int RING_DEPTH  = 256;
  localparam int SLOT_W      = $clog2(RING_DEPTH);
  localparam int SLOT_OUT_W  = 8;
  localparam int SLOT_EXT_W  = SLOT_W + SLOT_OUT_W;

  // configuration port
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CNT_W-1:0]   DECIM_RST = CNT_W'(8);
  localparam logic [SCALE_W-1:0] SCALE_RST = SCALE_W'(32'h0100_0000);

  localparam logic [RES_W-1:0] SAT_MAX = {1'b0, {(RES_W-1){1'b1}}};
  localparam logic [RES_W-1:0] SAT_MIN = {1'b1, {(RES_W-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DECIM       = 2'd0,
    CFG_CUR_SCALE   = 2'd1,
    CFG_VOLT_SCALE  = 2'd2
  } cfg_reg_t;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [RES_W-1:0]    result_t;

  // per-cycle controls shared by all lanes
  typedef struct packed {
    logic acc_en;   // add the accepted sample set
    logic clr;      // restart request: clear the sum
    logic dump;     // this set closes the window
    logic ld2;      // dump register -> magnitude stage
    logic ld3;      // magnitude stage -> product stage
    logic ld4;      // product stage -> output register
  } lane_ctl_t;

endpackage

FILE: design/scda_ifs.sv
// request and result channel interfaces
`timescale 1ns / 1ps

interface scda_in_if;
  logic                    valid;
  logic                    ready;
  logic                    restart;
  scda_pkg::sample_t       current_a;
  scda_pkg::sample_t       voltage_a;
  scda_pkg::sample_t       current_b;
  scda_pkg::sample_t       voltage_b;
  scda_pkg::sample_t       current_c;
  scda_pkg::sample_t       voltage_c;
  scda_pkg::sample_t       current_n;

  modport source (
    output valid, restart, current_a, voltage_a, current_b, voltage_b,
           current_c, voltage_c, current_n,
    input  ready
  );
  modport sink (
    input  valid, restart, current_a, voltage_a, current_b, voltage_b,
           current_c, voltage_c, current_n,
    output ready
  );
endinterface

interface scda_out_if;
  logic                                valid;
  logic                                ready;
  logic [scda_pkg::SLOT_OUT_W-1:0]     slot_index;
  scda_pkg::result_t                   scaled_current_a;
  scda_pkg::result_t                   scaled_voltage_a;
  scda_pkg::result_t                   scaled_current_b;
  scda_pkg::result_t                   scaled_voltage_b;
  scda_pkg::result_t                   scaled_current_c;
  scda_pkg::result_t                   scaled_voltage_c;
  scda_pkg::result_t                   scaled_current_n;

  modport source (
    output valid, slot_index, scaled_current_a, scaled_voltage_a,
           scaled_current_b, scaled_voltage_b, scaled_current_c,
           scaled_voltage_c, scaled_current_n,
    input  ready
  );
  modport sink (
    input  valid, slot_index, scaled_current_a, scaled_voltage_a,
           scaled_current_b, scaled_voltage_b, scaled_current_c,
           scaled_voltage_c, scaled_current_n,
    output ready
  );
endinterface

FILE: design/seven_channel_decimating_accumulator_unit.sv
// top level: seven accumulator lanes, shared control and result merge
//
// Integrate-and-dump decimator for seven signed sample channels.
// in_chan carries one sample set per request (valid/ready); a request with
// restart set clears the sums and the set counter and gives no result.
// Once the configured number of sample sets is summed (a count of 0 acts
// as 1) one result goes out on out_chan: each channel sum times its Q8.24
// scale, truncated toward zero and saturated to 32 bits, with the ring slot.
// Throughput: one request per cycle while out_chan takes results; the
// seven lanes work side by side and each has its own 31x32 multiplier.
// Pipeline: a result passes the dump, magnitude, multiply and saturate
// registers in turn, starting from the edge that took the closing set.
// Stall: when out_chan.ready is low the result holds; the lane pipeline
// keeps taking requests until all four stages are full of results.
// Reset (rst_n, synchronous): sums, counter and slot clear, registers take
// their defaults (factor 8, scales 1.0), no result is pending.
// Configuration is written through cfg_we/cfg_index/cfg_data while idle.
`timescale 1ns / 1ps

module seven_channel_decimating_accumulator_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  scda_in_if.sink                             in_chan,
  scda_out_if.source                          out_chan,
  input  logic                                cfg_we,
  input  logic [scda_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [scda_pkg::CFG_DATA_W-1:0]     cfg_data
);

  scda_pkg::lane_ctl_t               lane_ctl;
  logic [scda_pkg::SCALE_W-1:0]      cur_scale;
  logic [scda_pkg::SCALE_W-1:0]      volt_scale;
  scda_pkg::sample_t                 samples [scda_pkg::NUM_CH];
  scda_pkg::result_t                 results [scda_pkg::NUM_CH];

  // shared control
  scda_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_chan.valid),
    .in_restart (in_chan.restart),
    .in_ready   (in_chan.ready),
    .out_ready  (out_chan.ready),
    .out_valid  (out_chan.valid),
    .slot_index (out_chan.slot_index),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cur_scale  (cur_scale),
    .volt_scale (volt_scale),
    .lane_ctl   (lane_ctl)
  );

  // channel order Ia, Va, Ib, Vb, Ic, Vc, In
  assign samples[0] = in_chan.current_a;
  assign samples[1] = in_chan.voltage_a;
  assign samples[2] = in_chan.current_b;
  assign samples[3] = in_chan.voltage_b;
  assign samples[4] = in_chan.current_c;
  assign samples[5] = in_chan.voltage_c;
  assign samples[6] = in_chan.current_n;

  // lanes; odd lanes are voltages
  for (genvar i = 0; i < scda_pkg::NUM_CH; i++) begin : g_lane
    scda_lane u_lane (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl    (lane_ctl),
      .sample (samples[i]),
      .scale  ((i % 2 == 1) ? volt_scale : cur_scale),
      .result (results[i])
    );
  end

  // merge lane results into the result channel
  assign out_chan.scaled_current_a = results[0];
  assign out_chan.scaled_voltage_a = results[1];
  assign out_chan.scaled_current_b = results[2];
  assign out_chan.scaled_voltage_b = results[3];
  assign out_chan.scaled_current_c = results[4];
  assign out_chan.scaled_voltage_c = results[5];
  assign out_chan.scaled_current_n = results[6];

endmodule

FILE: design/scda_lane.sv
// one channel lane: running sum, magnitude, scale multiply and saturation
`timescale 1ns / 1ps

module scda_lane (
  input  logic                               clk,
  input  logic                               rst_n,
  input  scda_pkg::lane_ctl_t                ctl,
  input  scda_pkg::sample_t                  sample,
  input  logic [scda_pkg::SCALE_W-1:0]       scale,
  output scda_pkg::result_t                  result
);

  logic signed [scda_pkg::SUM_W-1:0]   sum_r;
  logic signed [scda_pkg::SUM_W-1:0]   sum_nxt;
  logic signed [scda_pkg::SUM_W-1:0]   sample_ext;
  logic signed [scda_pkg::SUM_W-1:0]   dump_r;
  logic                                neg2_r;
  logic [scda_pkg::SUM_W-1:0]          mag2_r;
  logic [scda_pkg::SUM_W-1:0]          mag_nxt;
  logic                                neg3_r;
  logic [scda_pkg::PROD_W-1:0]         prod3_r;
  logic [scda_pkg::PROD_W-1:0]         prod_nxt;
  logic [scda_pkg::SHIFTED_W-1:0]      shifted;
  logic [scda_pkg::RES_W-1:0]          sat_nxt;
  logic [scda_pkg::RES_W-1:0]          result_r;

  // sign extend the used sample bits and add
  assign sample_ext = {{(scda_pkg::SUM_W - scda_pkg::SAMPLE_BITS)
                         {sample[scda_pkg::SAMPLE_BITS-1]}},
                       sample[scda_pkg::SAMPLE_BITS-1:0]};
  assign sum_nxt = sum_r + sample_ext;

  // running sum, cleared on restart and on dump
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else if (ctl.clr || (ctl.acc_en && ctl.dump)) begin
      sum_r <= '0;
    end else if (ctl.acc_en) begin
      sum_r <= sum_nxt;
    end
  end

  // magnitude of the dumped sum
  assign mag_nxt = dump_r[scda_pkg::SUM_W-1] ? scda_pkg::SUM_W'(-dump_r)
                                             : scda_pkg::SUM_W'(dump_r);

  // unsigned magnitude times Q8.24 scale
  assign prod_nxt = scda_pkg::PROD_W'(mag2_r) * scda_pkg::PROD_W'(scale);

  // drop fraction bits, saturate and restore sign
  assign shifted = prod3_r[scda_pkg::PROD_W-1:scda_pkg::FRAC_BITS];

  always_comb begin
    if (neg3_r) begin
      if ((|shifted[scda_pkg::SHIFTED_W-1:scda_pkg::RES_W]) ||
          (shifted[scda_pkg::RES_W-1] && (|shifted[scda_pkg::RES_W-2:0]))) begin
        sat_nxt = scda_pkg::SAT_MIN;
      end else begin
        sat_nxt = scda_pkg::RES_W'(-shifted[scda_pkg::RES_W-1:0]);
      end
    end else begin
      if (|shifted[scda_pkg::SHIFTED_W-1:scda_pkg::RES_W-1]) begin
        sat_nxt = scda_pkg::SAT_MAX;
      end else begin
        sat_nxt = shifted[scda_pkg::RES_W-1:0];
      end
    end
  end

  // pipeline payload registers
  always_ff @(posedge clk) begin
    if (ctl.acc_en && ctl.dump) begin
      dump_r <= sum_nxt;
    end
    if (ctl.ld2) begin
      neg2_r <= dump_r[scda_pkg::SUM_W-1];
      mag2_r <= mag_nxt;
    end
    if (ctl.ld3) begin
      neg3_r  <= neg2_r;
      prod3_r <= prod_nxt;
    end
    if (ctl.ld4) begin
      result_r <= sat_nxt;
    end
  end

  assign result = scda_pkg::result_t'(result_r);

endmodule

FILE: design/scda_ctrl.sv
// set counter, ring slot, config registers and pipeline handshake control
`timescale 1ns / 1ps

module scda_ctrl (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_restart,
  output logic                                in_ready,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic [scda_pkg::SLOT_OUT_W-1:0]     slot_index,
  input  logic                                cfg_we,
  input  logic [scda_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [scda_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic [scda_pkg::SCALE_W-1:0]        cur_scale,
  output logic [scda_pkg::SCALE_W-1:0]        volt_scale,
  output scda_pkg::lane_ctl_t                 lane_ctl
);

  logic [scda_pkg::CNT_W-1:0]    decim_r;
  logic [scda_pkg::SCALE_W-1:0]  cur_scale_r;
  logic [scda_pkg::SCALE_W-1:0]  volt_scale_r;
  logic [scda_pkg::CNT_W-1:0]    cnt_r;
  logic [scda_pkg::CNT_W-1:0]    cnt_inc;
  logic [scda_pkg::SLOT_W-1:0]   slot_r;
  logic [scda_pkg::SLOT_W-1:0]   slot_nxt;
  logic [scda_pkg::SLOT_W-1:0]   slot1_r;
  logic [scda_pkg::SLOT_W-1:0]   slot2_r;
  logic [scda_pkg::SLOT_W-1:0]   slot3_r;
  logic [scda_pkg::SLOT_W-1:0]   slot_out_r;
  logic [scda_pkg::SLOT_EXT_W-1:0] slot_ext;
  logic                          v1_r, v2_r, v3_r, vout_r;
  logic                          fire, sample_fire, dump;
  logic                          ld2, ld3, ld4;

  // config register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decim_r      <= scda_pkg::DECIM_RST;
      cur_scale_r  <= scda_pkg::SCALE_RST;
      volt_scale_r <= scda_pkg::SCALE_RST;
    end else if (cfg_we) begin
      case (scda_pkg::cfg_reg_t'(cfg_index))
        scda_pkg::CFG_DECIM:      decim_r      <= cfg_data[scda_pkg::CNT_W-1:0];
        scda_pkg::CFG_CUR_SCALE:  cur_scale_r  <= cfg_data[scda_pkg::SCALE_W-1:0];
        scda_pkg::CFG_VOLT_SCALE: volt_scale_r <= cfg_data[scda_pkg::SCALE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign cur_scale  = cur_scale_r;
  assign volt_scale = volt_scale_r;

  // ready chain from the output register back to the dump register
  assign ld4      = v3_r && (!vout_r || out_ready);
  assign ld3      = v2_r && (!v3_r || ld4);
  assign ld2      = v1_r && (!v2_r || ld3);
  assign in_ready = !v1_r || ld2;

  // window count: increment first, then compare
  assign fire        = in_valid && in_ready;
  assign sample_fire = fire && !in_restart;
  assign cnt_inc     = cnt_r + scda_pkg::CNT_W'(1);
  assign dump        = !(cnt_inc < decim_r);

  assign slot_nxt = (slot_r == scda_pkg::SLOT_W'(scda_pkg::RING_DEPTH - 1))
                    ? '0 : slot_r + scda_pkg::SLOT_W'(1);

  // counter, slot and stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      slot_r <= '0;
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      v3_r   <= 1'b0;
      vout_r <= 1'b0;
    end else begin
      if (fire && in_restart) begin
        cnt_r <= '0;
      end else if (sample_fire) begin
        cnt_r <= dump ? '0 : cnt_inc;
      end
      if (sample_fire && dump) begin
        slot_r <= slot_nxt;
      end
      v1_r   <= (sample_fire && dump) || (v1_r && !ld2);
      v2_r   <= ld2 || (v2_r && !ld3);
      v3_r   <= ld3 || (v3_r && !ld4);
      vout_r <= ld4 || (vout_r && !out_ready);
    end
  end

  // slot travels alongside the lane pipeline
  always_ff @(posedge clk) begin
    if (sample_fire && dump) begin
      slot1_r <= slot_r;
    end
    if (ld2) begin
      slot2_r <= slot1_r;
    end
    if (ld3) begin
      slot3_r <= slot2_r;
    end
    if (ld4) begin
      slot_out_r <= slot3_r;
    end
  end

  assign slot_ext   = scda_pkg::SLOT_EXT_W'(slot_out_r);
  assign slot_index = slot_ext[scda_pkg::SLOT_OUT_W-1:0];
  assign out_valid  = vout_r;

  assign lane_ctl.acc_en = sample_fire;
  assign lane_ctl.clr    = fire && in_restart;
  assign lane_ctl.dump   = dump;
  assign lane_ctl.ld2    = ld2;
  assign lane_ctl.ld3    = ld3;
  assign lane_ctl.ld4    = ld4;

endmodule

FILE: design/scda_checker.sv
// port-level checks of the decimating accumulator and their bind
`timescale 1ns / 1ps

module scda_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_ready,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic [scda_pkg::SLOT_OUT_W-1:0]   slot_index
);

  logic [scda_pkg::SLOT_W-1:0]      exp_slot_r;
  logic [scda_pkg::SLOT_EXT_W-1:0]  exp_ext;

  // expected ring slot of the next result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_slot_r <= '0;
    end else if (out_valid && out_ready) begin
      exp_slot_r <= (exp_slot_r == scda_pkg::SLOT_W'(scda_pkg::RING_DEPTH - 1))
                    ? '0 : exp_slot_r + scda_pkg::SLOT_W'(1);
    end
  end

  assign exp_ext = scda_pkg::SLOT_EXT_W'(exp_slot_r);

  // results come out in consecutive ring slots
  a_slot_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> slot_index == exp_ext[scda_pkg::SLOT_OUT_W-1:0])
    else $error("result slot out of sequence");

  // with no result pending the block always takes a request
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("request refused with empty output");

  // a stalled result stays valid
  a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its slot
  a_slot_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(slot_index))
    else $error("result slot changed while stalled");

endmodule

bind seven_channel_decimating_accumulator_unit scda_checker u_scda_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_chan.ready),
  .out_valid  (out_chan.valid),
  .out_ready  (out_chan.ready),
  .slot_index (out_chan.slot_index)
);
